>>> rtl/core/position_pid_integral_separation_macros.svh
// ----------------------------------------------------------------------------
// position_pid_integral_separation assertion macros
// shared concurrent assertion forms, sampled on clock, masked by reset
// ----------------------------------------------------------------------------
`ifndef POSITION_PID_INTEGRAL_SEPARATION_MACROS_SVH
`define POSITION_PID_INTEGRAL_SEPARATION_MACROS_SVH

// same-cycle implication
`define PPIS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PPIS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/ppis_pkg.sv
// ----------------------------------------------------------------------------
// ppis_pkg
// types, widths, control word layout and microprogram of the pid core
// ----------------------------------------------------------------------------
package ppis_pkg;

   localparam int DATA_W      = 16;
   localparam int ERR_W       = DATA_W + 1;
   localparam int DIFF_W      = DATA_W + 2;
   localparam int GAIN_W      = 16;
   localparam int GAIN_FRAC   = 8;
   localparam int SUM_W       = 32;
   localparam int LIMIT_W     = 31;
   localparam int OUT_LIM_W   = 15;
   localparam int DRIVE_W     = 16;
   localparam int THR_W       = 16;
   localparam int WEIGHT_W    = 17;
   localparam int WEIGHT_FRAC = 16;
   localparam int WEIGHT_ONE  = 65536;
   localparam int MUL_A_W     = 33;
   localparam int MUL_B_W     = 17;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int ACC_W       = 50;
   localparam int REQ_W       = 2 * DATA_W;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int PC_W        = 4;
   localparam int DIV_STEPS   = WEIGHT_W;
   localparam int CNT_W       = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_P,
      REG_GAIN_I,
      REG_GAIN_D,
      REG_INTEGRAL_LIMIT,
      REG_OUTPUT_LIMIT,
      REG_SEPARATION_ON,
      REG_BEGIN_THRESHOLD,
      REG_FULL_THRESHOLD
   } csr_reg_type;

   typedef struct packed {
      logic [GAIN_W-1:0]    gain_p;
      logic [GAIN_W-1:0]    gain_i;
      logic [GAIN_W-1:0]    gain_d;
      logic [LIMIT_W-1:0]   integral_limit;
      logic [OUT_LIM_W-1:0] output_limit;
      logic                 separation_on;
      logic [THR_W-1:0]     begin_threshold;
      logic [THR_W-1:0]     full_threshold;
   } cfg_type;

   typedef enum logic [2:0] {
      S_NOP,
      S_ERR,
      S_CLASS,
      S_SUM,
      S_DIV,
      S_OUT
   } step_op_type;

   typedef enum logic [1:0] {
      MA_WEIGHT,
      MA_ERR,
      MA_DIFF,
      MA_SUM
   } mul_a_type;

   typedef enum logic [2:0] {
      MB_GAIN_P,
      MB_GAIN_I,
      MB_GAIN_D,
      MB_T_LO,
      MB_T_HI
   } mul_b_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_CLEAR,
      ACC_ADD,
      ACC_ADD_SHR
   } acc_op_type;

   typedef enum logic [1:0] {
      BR_NEXT,
      BR_SKIP,
      BR_LOOP,
      BR_DONE
   } branch_type;

   typedef struct packed {
      step_op_type      step_op;
      mul_a_type        mul_a;
      mul_b_type        mul_b;
      logic             mul_en;
      acc_op_type       acc_op;
      logic             t_load;
      branch_type       branch;
      logic [PC_W-1:0]  target;
   } ucode_type;

   typedef struct packed {
      ucode_type word;
      logic      fire;
      logic      load;
   } ctl_type;

   typedef struct packed {
      logic band;
      logic out_free;
   } stat_type;

   localparam logic [PC_W-1:0] PC_ERR   = PC_W'(0);
   localparam logic [PC_W-1:0] PC_CLASS = PC_W'(1);
   localparam logic [PC_W-1:0] PC_SUM   = PC_W'(2);
   localparam logic [PC_W-1:0] PC_DIV   = PC_W'(3);
   localparam logic [PC_W-1:0] PC_MGW   = PC_W'(4);
   localparam logic [PC_W-1:0] PC_MP    = PC_W'(5);
   localparam logic [PC_W-1:0] PC_MD    = PC_W'(6);
   localparam logic [PC_W-1:0] PC_MIL   = PC_W'(7);
   localparam logic [PC_W-1:0] PC_MIH   = PC_W'(8);
   localparam logic [PC_W-1:0] PC_ACC   = PC_W'(9);
   localparam logic [PC_W-1:0] PC_OUT   = PC_W'(10);

   function automatic ucode_type uw(
      input step_op_type     s,
      input mul_a_type       a,
      input mul_b_type       b,
      input logic            m,
      input acc_op_type      c,
      input logic            t,
      input branch_type      br,
      input logic [PC_W-1:0] tg
   );
      ucode_type w;
      w.step_op = s;
      w.mul_a   = a;
      w.mul_b   = b;
      w.mul_en  = m;
      w.acc_op  = c;
      w.t_load  = t;
      w.branch  = br;
      w.target  = tg;
      return w;
   endfunction

   // each product is registered and taken by the next step: t_load or the accumulator
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         PC_ERR:   w = uw(S_ERR, MA_ERR, MB_GAIN_P, 1'b0, ACC_HOLD, 1'b0, BR_NEXT, PC_ERR);
         PC_CLASS: w = uw(S_CLASS, MA_ERR, MB_GAIN_P, 1'b0, ACC_HOLD, 1'b0, BR_NEXT, PC_ERR);
         PC_SUM:   w = uw(S_SUM, MA_ERR, MB_GAIN_P, 1'b0, ACC_HOLD, 1'b0, BR_SKIP, PC_MGW);
         PC_DIV:   w = uw(S_DIV, MA_ERR, MB_GAIN_P, 1'b0, ACC_HOLD, 1'b0, BR_LOOP, PC_DIV);
         PC_MGW:   w = uw(S_NOP, MA_WEIGHT, MB_GAIN_I, 1'b1, ACC_CLEAR, 1'b0, BR_NEXT, PC_ERR);
         PC_MP:    w = uw(S_NOP, MA_ERR, MB_GAIN_P, 1'b1, ACC_HOLD, 1'b1, BR_NEXT, PC_ERR);
         PC_MD:    w = uw(S_NOP, MA_DIFF, MB_GAIN_D, 1'b1, ACC_ADD, 1'b0, BR_NEXT, PC_ERR);
         PC_MIL:   w = uw(S_NOP, MA_SUM, MB_T_LO, 1'b1, ACC_ADD, 1'b0, BR_NEXT, PC_ERR);
         PC_MIH:   w = uw(S_NOP, MA_SUM, MB_T_HI, 1'b1, ACC_ADD_SHR, 1'b0, BR_NEXT, PC_ERR);
         PC_ACC:   w = uw(S_NOP, MA_ERR, MB_GAIN_P, 1'b0, ACC_ADD, 1'b0, BR_NEXT, PC_ERR);
         PC_OUT:   w = uw(S_OUT, MA_ERR, MB_GAIN_P, 1'b0, ACC_HOLD, 1'b0, BR_DONE, PC_ERR);
         default:  w = uw(S_NOP, MA_ERR, MB_GAIN_P, 1'b0, ACC_HOLD, 1'b0, BR_NEXT, PC_ERR);
      endcase
      return w;
   endfunction

endpackage

>>> rtl/core/ppis_csr.sv
// ----------------------------------------------------------------------------
// ppis_csr
// configuration register file, one register per write beat
// ----------------------------------------------------------------------------
module ppis_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ppis_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ppis_pkg::CSR_DATA_W-1:0] csr_data,
   output ppis_pkg::cfg_type               cfg
);
   import ppis_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            REG_GAIN_P:          cfg_in.gain_p          = csr_data[GAIN_W-1:0];
            REG_GAIN_I:          cfg_in.gain_i          = csr_data[GAIN_W-1:0];
            REG_GAIN_D:          cfg_in.gain_d          = csr_data[GAIN_W-1:0];
            REG_INTEGRAL_LIMIT:  cfg_in.integral_limit  = csr_data[LIMIT_W-1:0];
            REG_OUTPUT_LIMIT:    cfg_in.output_limit    = csr_data[OUT_LIM_W-1:0];
            REG_SEPARATION_ON:   cfg_in.separation_on   = csr_data[0];
            REG_BEGIN_THRESHOLD: cfg_in.begin_threshold = csr_data[THR_W-1:0];
            REG_FULL_THRESHOLD:  cfg_in.full_threshold  = csr_data[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p          <= '0;
         cfg_ff.gain_i          <= '0;
         cfg_ff.gain_d          <= '0;
         cfg_ff.integral_limit  <= '0;
         cfg_ff.output_limit    <= '1;
         cfg_ff.separation_on   <= 1'b0;
         cfg_ff.begin_threshold <= '1;
         cfg_ff.full_threshold  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/core/ppis_seq.sv
// ----------------------------------------------------------------------------
// ppis_seq
// microprogram sequencer: step counter, loop counter and branch logic
// ----------------------------------------------------------------------------
`include "position_pid_integral_separation_macros.svh"

module ppis_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  ppis_pkg::stat_type stat,
   output ppis_pkg::ctl_type  ctl
);
   import ppis_pkg::*;

   logic             busy_ff;
   logic             busy_in;
   logic [PC_W-1:0]  pc_ff;
   logic [PC_W-1:0]  pc_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   ucode_type        word_w;
   logic             fire_w;

   assign word_w     = ucode_rom(pc_ff);
   assign fire_w     = busy_ff && ((word_w.branch != BR_DONE) || stat.out_free);
   assign req_tready = !busy_ff;
   assign ctl.word   = word_w;
   assign ctl.fire   = fire_w;
   assign ctl.load   = req_tvalid && !busy_ff;

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      cnt_in  = cnt_ff;
      if (!busy_ff) begin
         if (req_tvalid) begin
            busy_in = 1'b1;
            pc_in   = PC_ERR;
            cnt_in  = '0;
         end
      end else if (fire_w) begin
         case (word_w.branch)
            BR_NEXT: pc_in = pc_ff + PC_W'(1);
            BR_SKIP: pc_in = stat.band ? pc_ff + PC_W'(1) : word_w.target;
            BR_LOOP: begin
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
                  cnt_in = '0;
                  pc_in  = pc_ff + PC_W'(1);
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
                  pc_in  = word_w.target;
               end
            end
            BR_DONE: begin
               busy_in = 1'b0;
               pc_in   = PC_ERR;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= PC_ERR;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
         cnt_ff  <= cnt_in;
      end
   end

   `PPIS_ASSERT_NOW(a_seq_pc_range, busy_ff, pc_ff <= PC_OUT, "step counter beyond program")
   `PPIS_ASSERT_NOW(a_seq_cnt_div, cnt_ff != '0, pc_ff == PC_DIV, "loop count outside divide")
   `PPIS_ASSERT_NEXT(a_seq_load, ctl.load, busy_ff && pc_ff == PC_ERR, "beat not started")

endmodule

>>> rtl/core/ppis_dp.sv
// ----------------------------------------------------------------------------
// ppis_dp
// datapath: error, weight divider, shared multiplier, accumulator, result
// ----------------------------------------------------------------------------
`include "position_pid_integral_separation_macros.svh"

module ppis_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  ppis_pkg::ctl_type           ctl,
   input  ppis_pkg::cfg_type           cfg,
   input  logic [ppis_pkg::REQ_W-1:0]  req_tdata,
   output ppis_pkg::stat_type          stat,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ppis_pkg::DRIVE_W-1:0] rsp_tdata
);
   import ppis_pkg::*;

   logic signed [DATA_W-1:0]  target_ff, target_in;
   logic signed [DATA_W-1:0]  measured_ff, measured_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [ERR_W-1:0]   prev_err_ff, prev_err_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [SUM_W-1:0]   error_sum_ff, error_sum_in;
   logic                      band_ff, band_in;
   logic                      add_ff, add_in;
   logic [WEIGHT_W-1:0]       weight_ff, weight_in;
   logic [WEIGHT_W-1:0]       rem_ff, rem_in;
   logic [THR_W-1:0]          span_ff, span_in;
   logic [SUM_W-1:0]          t_ff, t_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DRIVE_W-1:0]        rsp_data_ff, rsp_data_in;

   logic [ERR_W-1:0]          mag_w;
   logic [ERR_W-1:0]          begin_w;
   logic [ERR_W-1:0]          full_w;
   logic [WEIGHT_W-1:0]       trial_w;
   logic                      ge_w;
   logic signed [SUM_W:0]     sum_w;
   logic signed [SUM_W:0]     ilim_w;
   logic signed [ACC_W-1:0]   shift_w;
   logic signed [ACC_W-1:0]   olim_w;
   logic signed [DRIVE_W-1:0] drive_w;
   logic signed [DRIVE_W-1:0] olim16_w;
   logic signed [MUL_A_W-1:0] mul_a_w;
   logic signed [MUL_B_W-1:0] mul_b_w;

   assign mag_w   = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);
   assign begin_w = ERR_W'(cfg.begin_threshold);
   assign full_w  = ERR_W'(cfg.full_threshold);

   // restoring divide, one quotient bit per step
   assign ge_w    = rem_ff >= WEIGHT_W'(span_ff);
   assign trial_w = ge_w ? rem_ff - WEIGHT_W'(span_ff) : rem_ff;

   assign sum_w   = (SUM_W+1)'(error_sum_ff) + (add_ff ? (SUM_W+1)'(err_ff) : '0);
   assign ilim_w  = $signed((SUM_W+1)'(cfg.integral_limit));

   assign shift_w  = acc_ff >>> GAIN_FRAC;
   assign olim_w   = $signed(ACC_W'(cfg.output_limit));
   assign olim16_w = $signed(DRIVE_W'(cfg.output_limit));
   assign drive_w  = (shift_w > olim_w) ? olim16_w :
                     (shift_w < -olim_w) ? -olim16_w : shift_w[DRIVE_W-1:0];

   always_comb begin
      case (ctl.word.mul_a)
         MA_WEIGHT: mul_a_w = $signed(MUL_A_W'(weight_ff));
         MA_ERR:    mul_a_w = MUL_A_W'(err_ff);
         MA_DIFF:   mul_a_w = MUL_A_W'(diff_ff);
         MA_SUM:    mul_a_w = MUL_A_W'(error_sum_ff);
         default:   mul_a_w = '0;
      endcase
      case (ctl.word.mul_b)
         MB_GAIN_P: mul_b_w = $signed({1'b0, cfg.gain_p});
         MB_GAIN_I: mul_b_w = $signed({1'b0, cfg.gain_i});
         MB_GAIN_D: mul_b_w = $signed({1'b0, cfg.gain_d});
         MB_T_LO:   mul_b_w = $signed({1'b0, t_ff[WEIGHT_FRAC-1:0]});
         MB_T_HI:   mul_b_w = $signed({1'b0, t_ff[SUM_W-1:WEIGHT_FRAC]});
         default:   mul_b_w = '0;
      endcase
   end

   always_comb begin
      target_in    = target_ff;
      measured_in  = measured_ff;
      err_in       = err_ff;
      prev_err_in  = prev_err_ff;
      diff_in      = diff_ff;
      error_sum_in = error_sum_ff;
      band_in      = band_ff;
      add_in       = add_ff;
      weight_in    = weight_ff;
      rem_in       = rem_ff;
      span_in      = span_ff;
      t_in         = t_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (ctl.load) begin
         target_in   = req_tdata[DATA_W-1:0];
         measured_in = req_tdata[REQ_W-1:DATA_W];
      end
      if (ctl.fire) begin
         case (ctl.word.step_op)
            S_ERR: err_in = ERR_W'(target_ff) - ERR_W'(measured_ff);
            S_CLASS: begin
               rem_in  = begin_w - mag_w;
               span_in = cfg.begin_threshold - cfg.full_threshold;
               band_in = 1'b0;
               add_in  = 1'b1;
               weight_in = WEIGHT_W'(WEIGHT_ONE);
               if (cfg.separation_on) begin
                  if (mag_w > begin_w) begin
                     weight_in = '0;
                     add_in    = 1'b0;
                  end else if (mag_w < full_w) begin
                     weight_in = WEIGHT_W'(WEIGHT_ONE);
                  end else if (cfg.begin_threshold == cfg.full_threshold) begin
                     weight_in = WEIGHT_W'(WEIGHT_ONE);
                  end else begin
                     weight_in = '0;
                     band_in   = 1'b1;
                  end
               end
            end
            S_SUM: begin
               if (sum_w > ilim_w) begin
                  error_sum_in = ilim_w[SUM_W-1:0];
               end else if (sum_w < -ilim_w) begin
                  error_sum_in = SUM_W'(-ilim_w);
               end else begin
                  error_sum_in = sum_w[SUM_W-1:0];
               end
               diff_in     = DIFF_W'(err_ff) - DIFF_W'(prev_err_ff);
               prev_err_in = err_ff;
            end
            S_DIV: begin
               rem_in    = {trial_w[WEIGHT_W-2:0], 1'b0};
               weight_in = {weight_ff[WEIGHT_W-2:0], ge_w};
            end
            S_OUT: begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = drive_w;
            end
            default: ;
         endcase
         if (ctl.word.mul_en) begin
            prod_in = PROD_W'(mul_a_w * mul_b_w);
         end
         if (ctl.word.t_load) begin
            t_in = prod_ff[SUM_W-1:0];
         end
         case (ctl.word.acc_op)
            ACC_CLEAR:   acc_in = '0;
            ACC_ADD:     acc_in = acc_ff + ACC_W'(prod_ff);
            ACC_ADD_SHR: acc_in = acc_ff + ACC_W'(prod_ff >>> WEIGHT_FRAC);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         error_sum_ff <= '0;
         prev_err_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         error_sum_ff <= error_sum_in;
         prev_err_ff  <= prev_err_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      measured_ff <= measured_in;
      err_ff      <= err_in;
      diff_ff     <= diff_in;
      band_ff     <= band_in;
      add_ff      <= add_in;
      weight_ff   <= weight_in;
      rem_ff      <= rem_in;
      span_ff     <= span_in;
      t_ff        <= t_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign stat.band     = band_ff;
   assign stat.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;

   `PPIS_ASSERT_NEXT(a_dp_sum_clamp, ctl.fire && ctl.word.step_op == S_SUM, (SUM_W+1)'(error_sum_ff) <= ilim_w && (SUM_W+1)'(error_sum_ff) >= -ilim_w, "integral outside limit")
   `PPIS_ASSERT_NOW(a_dp_weight, ctl.fire && ctl.word.step_op == S_OUT, weight_ff <= WEIGHT_W'(WEIGHT_ONE), "weight above one")
   `PPIS_ASSERT_NEXT(a_dp_drive, ctl.fire && ctl.word.step_op == S_OUT, rsp_valid_ff && $signed(rsp_data_ff) <= olim16_w && $signed(rsp_data_ff) >= -olim16_w, "drive beat wrong")

endmodule

>>> rtl/core/position_pid_integral_separation.sv
// ----------------------------------------------------------------------------
// position_pid_integral_separation
// positional pid step with integral separation, microcoded datapath
//
//   channel   dir   handshake             payload
//   req_      in    req_tvalid/tready     tdata: target, measured
//   rsp_      out   rsp_tvalid/tready     tdata: drive
//   csr_      in    csr_valid/ready       csr_index, csr_data
//
// a beat is taken only when no earlier beat is in progress. the 17-step
// restoring divider forming the integral weight runs only when the error
// lies in the separation band; the result appears the cycle after the last
// step. synchronous reset clears sequencer state, integral sum, previous
// error and result valid, and sets config defaults. a beat is taken while a
// result waits; its last step holds until the result register is free.
// ----------------------------------------------------------------------------
module position_pid_integral_separation (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ppis_pkg::REQ_W-1:0]      req_tdata,   // target, measured
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ppis_pkg::DRIVE_W-1:0]    rsp_tdata,   // drive
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ppis_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ppis_pkg::CSR_DATA_W-1:0] csr_data
);
   import ppis_pkg::*;

   cfg_type  cfg;
   ctl_type  ctl;
   stat_type stat;

   ppis_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ppis_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctl        (ctl)
   );

   ppis_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .cfg        (cfg),
      .req_tdata  (req_tdata),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
